### hw/rtl/lane_snap_pointer_selector_macros.svh
// assertion macros for the lane snap pointer selector
`ifndef LANE_SNAP_POINTER_SELECTOR_MACROS_SVH
`define LANE_SNAP_POINTER_SELECTOR_MACROS_SVH

// clocked assertion, masked while reset is high
`define LSPS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define LSPS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/lsps_pkg.sv
`timescale 1ns / 1ps
package lsps_pkg;

  localparam int LSPS_MAX_POINTS = 16;

  localparam int PX_W   = 15;
  localparam int PT_W   = 19;
  localparam int POS_W  = 22;
  localparam int MAG_W  = 22;
  localparam int SQ_W   = 44;
  localparam int WGT_W  = 12;
  localparam int SUM_W  = 57;
  localparam int TOL_W  = 12;

  localparam int NUM_W  = 27;
  localparam int QUO_W  = 20;
  localparam int DIV_ROUND = 127;
  // divide by 254 as a halving, then a multiply by the reciprocal of 127
  localparam int RCP_W     = 27;
  localparam int DIV_RECIP = 67637281;
  localparam int DIV_SHIFT = 33;

  localparam logic [1:0] OP_MOVE_X = 2'd0;
  localparam logic [1:0] OP_MOVE_Y = 2'd1;
  localparam logic [1:0] OP_APPEND = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [2:0] REG_TARGET_LEFT   = 3'd0;
  localparam logic [2:0] REG_TARGET_TOP    = 3'd1;
  localparam logic [2:0] REG_TARGET_WIDTH  = 3'd2;
  localparam logic [2:0] REG_TARGET_HEIGHT = 3'd3;
  localparam logic [2:0] REG_LANE_TOL      = 3'd4;
  localparam logic [2:0] REG_X_WEIGHT      = 3'd5;
  localparam logic [2:0] REG_Y_WEIGHT      = 3'd6;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic signed [PX_W-1:0] sat_px(input logic signed [POS_W-1:0] a);
    logic signed [PX_W-1:0] r;
    if (a < -POS_W'(16384)) r = -PX_W'(16384);
    else if (a > POS_W'(16383)) r = PX_W'(16383);
    else r = a[PX_W-1:0];
    return r;
  endfunction

  function automatic logic signed [PX_W-1:0] round_px(input logic signed [POS_W-1:0] a);
    logic [POS_W-1:0] m;
    logic [POS_W:0] t;
    logic signed [POS_W-1:0] r;
    m = a[POS_W-1] ? POS_W'(-a) : POS_W'(a);
    t = (POS_W+1)'(m) + (POS_W+1)'(8);
    r = $signed(POS_W'(t >> 4));
    if (a[POS_W-1]) r = -r;
    return sat_px(r);
  endfunction

  function automatic logic [MAG_W-1:0] abs_diff(input logic signed [POS_W-1:0] a,
                                                input logic signed [POS_W-1:0] b);
    logic signed [POS_W:0] d;
    d = (POS_W+1)'(a) - (POS_W+1)'(b);
    return d[POS_W] ? MAG_W'(-d) : MAG_W'(d);
  endfunction

endpackage

### hw/rtl/lane_snap_pointer_selector.sv
`timescale 1ns / 1ps
`include "lane_snap_pointer_selector_macros.svh"
// Lane snap pointer selector. Turns 7-bit controller moves into a virtual
// pointer inside the target rectangle and snaps the cursor to one of up to
// MAX_POINTS stored points, preferring points on the locked lane. One
// transaction is worked at a time; in_stall is high while it runs. An append
// or clear needs only the output hand-off when a result is given. A move
// places the virtual coordinate through the divider (the divide by 254 is a
// reciprocal multiply), then, with points stored, runs the lane scan and,
// when no point is on the lane, the weighted-distance scan, which runs one
// shared multiplier four times per point; the pick and emit states deliver
// the result. A last point costs the weighted scan without the divide.
// Results sit in an output register, so a new transaction is taken while
// one waits.
module lane_snap_pointer_selector import lsps_pkg::*; #(
  parameter int MAX_POINTS = LSPS_MAX_POINTS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [2:0]             cfg_index,
  input  logic [14:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             opcode,
  input  logic [6:0]             ctrl_value,
  input  logic signed [PT_W-1:0] point_x,
  input  logic signed [PT_W-1:0] point_y,
  input  logic                   last_point,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [PX_W-1:0] cursor_x,
  output logic signed [PX_W-1:0] cursor_y,
  output logic                   point_chosen,
  output logic [3:0]             chosen_index
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int RW = 2 * PT_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_SCAN_RD, ST_SCAN_CHK, ST_W_RD, ST_W_LOAD, ST_W_RUN,
    ST_PICK, ST_EMIT
  } state_t;

  typedef enum logic [1:0] {AX_NONE, AX_X, AX_Y} axis_t;

  state_t state;
  axis_t  last_axis;

  logic signed [PX_W-1:0] target_left, target_top;
  logic [14:0]            target_width, target_height;
  logic [7:0]             lane_tolerance;
  logic [WGT_W-1:0]       x_weight, y_weight;

  logic signed [POS_W-1:0] virt_x, virt_y, lock_x, lock_y;
  logic signed [PX_W-1:0]  cur_x, cur_y;
  logic [CW-1:0]           point_count;
  logic                    list_closed;
  logic                    chosen_valid;
  logic [AW-1:0]           chosen_entry;
  logic                    move_y;
  logic [AW-1:0]           idx;
  logic                    found;
  logic [AW-1:0]           best;
  logic [MAG_W-1:0]        best_d, best_off;
  logic [SUM_W-1:0]        best_w;
  logic signed [POS_W-1:0] best_x, best_y, cand_x, cand_y;

  logic                    accept, has_target, idx_last;
  logic [CW-1:0]           cnt_eff;
  logic                    ram_we;
  logic [RW-1:0]           rdata;
  logic signed [POS_W-1:0] rd_x, rd_y;
  logic [TOL_W-1:0]        tol16;
  logic [MAG_W-1:0]        lane_off, lane_d;
  logic                    lane_hit, lane_better;
  logic [WGT_W-1:0]        wx_eff, wy_eff;
  logic                    div_start, dist_start;
  unit_stat_t              div_stat, dist_stat;
  logic [QUO_W-1:0]        quotient;
  logic [SUM_W-1:0]        dist_sum;
  logic signed [POS_W-1:0] move_pos;
  logic signed [PX_W-1:0]  clr_x, clr_y;

  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign has_target = (target_width != '0) && (target_height != '0);
  assign cnt_eff    = list_closed ? '0 : point_count;
  assign ram_we     = accept && (opcode == OP_APPEND) && has_target
                      && (cnt_eff < CW'(MAX_POINTS));
  assign idx_last   = (CW'(idx) + CW'(1)) == point_count;

  lsps_ram #(.WIDTH(RW), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_eff[AW-1:0]),
    .wdata ({point_x, point_y}),
    .raddr (idx),
    .rdata (rdata)
  );

  assign rd_x = POS_W'($signed(rdata[RW-1:PT_W]));
  assign rd_y = POS_W'($signed(rdata[PT_W-1:0]));

  // lane tolerance clamped to 1..128, in sixteenths
  always_comb begin
    if (lane_tolerance == 8'd0) tol16 = TOL_W'(16);
    else if (lane_tolerance > 8'd128) tol16 = TOL_W'(2048);
    else tol16 = {lane_tolerance[7:0], 4'b0};
  end

  assign lane_off = (last_axis == AX_X) ? abs_diff(rd_y, lock_y) : abs_diff(rd_x, lock_x);
  assign lane_d   = (last_axis == AX_X) ? abs_diff(rd_x, virt_x) : abs_diff(rd_y, virt_y);
  assign lane_hit = lane_off <= MAG_W'(tol16);
  assign lane_better = !found || (lane_d < best_d) || (lane_d == best_d && lane_off < best_off);

  assign wx_eff = (x_weight == '0) ? WGT_W'(1) : x_weight;
  assign wy_eff = (y_weight == '0) ? WGT_W'(1) : y_weight;

  assign div_start  = accept && (opcode == OP_MOVE_X || opcode == OP_MOVE_Y) && has_target;
  assign dist_start = (state == ST_W_LOAD);

  lsps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .value    (ctrl_value),
    .size     (opcode == OP_MOVE_Y ? target_height : target_width),
    .stat     (div_stat),
    .quotient (quotient)
  );

  lsps_dist u_dist (
    .clk   (clk),
    .rst   (rst),
    .start (dist_start),
    .dx    (abs_diff(rd_x, virt_x)),
    .dy    (abs_diff(rd_y, virt_y)),
    .wx    (wx_eff),
    .wy    (wy_eff),
    .stat  (dist_stat),
    .sum   (dist_sum)
  );

  assign move_pos = POS_W'($signed({(move_y ? target_top : target_left), 4'b0}))
                    + POS_W'($signed({2'b0, quotient}));
  assign clr_x = sat_px(POS_W'(target_left) + POS_W'($signed({1'b0, target_width[14:1]})));
  assign clr_y = sat_px(POS_W'(target_top) + POS_W'($signed({1'b0, target_height[14:1]})));

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      last_axis      <= AX_NONE;
      target_left    <= '0;
      target_top     <= '0;
      target_width   <= '0;
      target_height  <= '0;
      lane_tolerance <= 8'd8;
      x_weight       <= WGT_W'(256);
      y_weight       <= WGT_W'(256);
      virt_x         <= '0;
      virt_y         <= '0;
      lock_x         <= '0;
      lock_y         <= '0;
      cur_x          <= '0;
      cur_y          <= '0;
      point_count    <= '0;
      list_closed    <= 1'b0;
      chosen_valid   <= 1'b0;
      chosen_entry   <= '0;
      out_valid      <= 1'b0;
      found          <= 1'b0;
      idx            <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_TARGET_LEFT:   target_left    <= cfg_data;
          REG_TARGET_TOP:    target_top     <= cfg_data;
          REG_TARGET_WIDTH:  target_width   <= cfg_data;
          REG_TARGET_HEIGHT: target_height  <= cfg_data;
          REG_LANE_TOL:      lane_tolerance <= cfg_data[7:0];
          REG_X_WEIGHT:      x_weight       <= cfg_data[WGT_W-1:0];
          REG_Y_WEIGHT:      y_weight       <= cfg_data[WGT_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall && state != ST_EMIT) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (opcode) inside
              OP_MOVE_X, OP_MOVE_Y: begin
                move_y <= (opcode == OP_MOVE_Y);
                if (has_target) state <= ST_DIV;
              end
              OP_APPEND: begin
                if (list_closed) begin
                  list_closed  <= 1'b0;
                  chosen_valid <= 1'b0;
                  chosen_entry <= '0;
                  last_axis    <= AX_NONE;
                end
                point_count <= cnt_eff;
                if (has_target) begin
                  if (ram_we) point_count <= cnt_eff + CW'(1);
                  if (last_point) begin
                    list_closed <= 1'b1;
                    last_axis   <= AX_NONE;
                    lock_x      <= POS_W'($signed({cur_x, 4'b0}));
                    lock_y      <= POS_W'($signed({cur_y, 4'b0}));
                    idx         <= '0;
                    found       <= 1'b0;
                    state       <= ST_W_RD;
                  end
                end
              end
              default: begin
                point_count  <= '0;
                list_closed  <= 1'b0;
                last_axis    <= AX_NONE;
                chosen_valid <= 1'b0;
                chosen_entry <= '0;
                cur_x        <= clr_x;
                cur_y        <= clr_y;
                virt_x       <= POS_W'($signed({clr_x, 4'b0}));
                virt_y       <= POS_W'($signed({clr_y, 4'b0}));
                lock_x       <= POS_W'($signed({clr_x, 4'b0}));
                lock_y       <= POS_W'($signed({clr_y, 4'b0}));
                if (has_target) state <= ST_EMIT;
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            if (move_y) begin
              virt_y    <= move_pos;
              lock_y    <= move_pos;
              last_axis <= AX_Y;
            end else begin
              virt_x    <= move_pos;
              lock_x    <= move_pos;
              last_axis <= AX_X;
            end
            idx   <= '0;
            found <= 1'b0;
            if (point_count != '0) begin
              state <= ST_SCAN_RD;
            end else begin
              chosen_valid <= 1'b0;
              chosen_entry <= '0;
              if (move_y) cur_y <= round_px(move_pos);
              else cur_x <= round_px(move_pos);
              state <= ST_EMIT;
            end
          end
        end
        ST_SCAN_RD: state <= ST_SCAN_CHK;
        ST_SCAN_CHK: begin
          if (lane_hit && lane_better) begin
            found    <= 1'b1;
            best     <= idx;
            best_d   <= lane_d;
            best_off <= lane_off;
            best_x   <= rd_x;
            best_y   <= rd_y;
          end
          if (idx_last) begin
            idx <= '0;
            if (found || lane_hit) state <= ST_PICK;
            else state <= ST_W_RD;
          end else begin
            idx   <= idx + AW'(1);
            state <= ST_SCAN_RD;
          end
        end
        ST_W_RD: state <= ST_W_LOAD;
        ST_W_LOAD: begin
          cand_x <= rd_x;
          cand_y <= rd_y;
          state  <= ST_W_RUN;
        end
        ST_W_RUN: begin
          if (dist_stat.done) begin
            if (!found || dist_sum < best_w) begin
              found  <= 1'b1;
              best   <= idx;
              best_w <= dist_sum;
              best_x <= cand_x;
              best_y <= cand_y;
            end
            if (idx_last) begin
              state <= ST_PICK;
            end else begin
              idx   <= idx + AW'(1);
              state <= ST_W_RD;
            end
          end
        end
        ST_PICK: begin
          chosen_valid <= 1'b1;
          chosen_entry <= best;
          cur_x        <= round_px(best_x);
          cur_y        <= round_px(best_y);
          state        <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            cursor_x     <= cur_x;
            cursor_y     <= cur_y;
            point_chosen <= chosen_valid;
            chosen_index <= chosen_valid ? 4'(chosen_entry) : 4'd0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `LSPS_ASSERT(a_result_from_emit, clk, rst, $rose(out_valid) |-> $past(state == ST_EMIT), "result not from emit")
  `LSPS_ASSERT(a_count_bound, clk, rst, point_count <= CW'(MAX_POINTS), "point count overflow")
  `LSPS_ASSERT(a_index_zero, clk, rst, (out_valid && !point_chosen) |-> (chosen_index == 4'd0), "index without point")
  `LSPS_ASSERT_ALWAYS(a_reset_idle, clk, (!rst && $past(rst)) |-> (state == ST_IDLE && !out_valid), "not idle after reset")

endmodule

### hw/rtl/lsps_ram.sv
`timescale 1ns / 1ps
module lsps_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/lsps_div.sv
`timescale 1ns / 1ps
module lsps_div import lsps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [6:0]        value,
  input  logic [14:0]       size,
  output unit_stat_t        stat,
  output logic [QUO_W-1:0]  quotient
);

  localparam int PRD_W = NUM_W - 1 + RCP_W;

  logic [NUM_W-1:0] num;
  logic [QUO_W-1:0] quo;
  logic             busy;
  logic             done;
  logic [21:0]      vs;
  logic [PRD_W-1:0] prod;

  assign vs   = 22'(value) * 22'(size);
  assign prod = PRD_W'(num[NUM_W-1:1]) * PRD_W'(DIV_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num  <= NUM_W'({vs, 5'b0}) + NUM_W'(DIV_ROUND);
        busy <= 1'b1;
      end else if (busy) begin
        quo  <= prod[DIV_SHIFT +: QUO_W];
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quotient = quo;
  assign stat = '{busy: busy, done: done};

endmodule

### hw/rtl/lsps_dist.sv
`timescale 1ns / 1ps
module lsps_dist import lsps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MAG_W-1:0]  dx,
  input  logic [MAG_W-1:0]  dy,
  input  logic [WGT_W-1:0]  wx,
  input  logic [WGT_W-1:0]  wy,
  output unit_stat_t        stat,
  output logic [SUM_W-1:0]  sum
);

  logic [MAG_W-1:0]      dxr, dyr;
  logic [WGT_W-1:0]      wxr, wyr;
  logic [1:0]            step;
  logic                  busy, done;
  logic [SQ_W-1:0]       sq;
  logic [SUM_W-1:0]      acc;
  logic [SQ_W-1:0]       mul_a;
  logic [MAG_W-1:0]      mul_b;
  logic [SQ_W+MAG_W-1:0] prod;

  // one shared multiplier: dx*dx, *wx, dy*dy, *wy
  always_comb begin
    case (step)
      2'd0: begin
        mul_a = SQ_W'(dxr);
        mul_b = dxr;
      end
      2'd1: begin
        mul_a = sq;
        mul_b = MAG_W'(wxr);
      end
      2'd2: begin
        mul_a = SQ_W'(dyr);
        mul_b = dyr;
      end
      default: begin
        mul_a = sq;
        mul_b = MAG_W'(wyr);
      end
    endcase
  end

  assign prod = (SQ_W+MAG_W)'(mul_a) * (SQ_W+MAG_W)'(mul_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dxr  <= dx;
        dyr  <= dy;
        wxr  <= wx;
        wyr  <= wy;
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        case (step)
          2'd0: sq <= prod[SQ_W-1:0];
          2'd1: acc <= SUM_W'(prod);
          2'd2: sq <= prod[SQ_W-1:0];
          default: begin
            acc  <= acc + SUM_W'(prod);
            busy <= 1'b0;
            done <= 1'b1;
          end
        endcase
        step <= step + 2'd1;
      end
    end
  end

  assign sum = acc;
  assign stat = '{busy: busy, done: done};

endmodule

### tb/tb_lane_snap_pointer_selector.sv
`timescale 1ns / 1ps
module tb_lane_snap_pointer_selector;
  import lsps_pkg::*;

  typedef enum logic [1:0] {AX_NONE, AX_X, AX_Y} axis_t;

  typedef struct {
    logic [1:0]  op;
    logic [6:0]  cv;
    logic [18:0] px;
    logic [18:0] py;
    logic        lp;
  } cmd_t;

  typedef struct {
    logic [14:0] cx;
    logic [14:0] cy;
    logic        hit;
    logic [3:0]  idx;
  } cursor_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [2:0] cfg_index = '0;
  logic [14:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] opcode = '0;
  logic [6:0] ctrl_value = '0;
  logic signed [PT_W-1:0] point_x = '0;
  logic signed [PT_W-1:0] point_y = '0;
  logic last_point = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [PX_W-1:0] cursor_x;
  logic signed [PX_W-1:0] cursor_y;
  logic point_chosen;
  logic [3:0] chosen_index;

  lane_snap_pointer_selector uut (.*);

  initial forever #2 clk = ~clk;

  cmd_t    pending[$];
  cursor_t cursors_due[$];
  int      errors = 0;
  bit      bursts_on = 1;
  int      in_gap = 0;
  int      out_gap = 0;

  // predictor state and registers
  longint  t_left, t_top, t_w, t_h, lane_tol, wt_x, wt_y;
  longint  tab_x[LSPS_MAX_POINTS], tab_y[LSPS_MAX_POINTS];
  int      n_pts;
  longint  virt_x, virt_y, cur_x, cur_y, lane_x, lane_y;
  axis_t   axis;
  bit      sel_ok;
  int      sel_idx;
  bit      list_done;

  function automatic longint absl(longint a);
    return a < 0 ? -a : a;
  endfunction

  function automatic longint sat_pix(longint a);
    if (a < -16384) return -16384;
    if (a > 16383) return 16383;
    return a;
  endfunction

  function automatic longint round_pix(longint a);
    if (a >= 0) return (a + 8) / 16;
    return -((-a + 8) / 16);
  endfunction

  task automatic reset_predictor();
    t_left = 0; t_top = 0; t_w = 0; t_h = 0;
    lane_tol = 8; wt_x = 256; wt_y = 256;
    n_pts = 0;
    virt_x = 0; virt_y = 0; cur_x = 0; cur_y = 0; lane_x = 0; lane_y = 0;
    axis = AX_NONE; sel_ok = 0; sel_idx = 0; list_done = 0;
  endtask

  task automatic snap_to_point();
    longint tol, d, off, bd, boff;
    longint unsigned w, bw, dx, dy, wx, wy;
    bit found;
    int best;
    tol = lane_tol < 1 ? 1 : (lane_tol > 128 ? 128 : lane_tol);
    tol = tol * 16;
    found = 0; best = 0; bd = 0; boff = 0; bw = 0;
    sel_ok = 0; sel_idx = 0;
    if (n_pts == 0) return;
    if (axis != AX_NONE) begin
      for (int i = 0; i < n_pts; i++) begin
        if (axis == AX_X) begin
          off = absl(tab_y[i] - lane_y);
          d = absl(tab_x[i] - virt_x);
        end else begin
          off = absl(tab_x[i] - lane_x);
          d = absl(tab_y[i] - virt_y);
        end
        if (off <= tol && (!found || d < bd || (d == bd && off < boff))) begin
          found = 1; bd = d; boff = off; best = i;
        end
      end
    end
    if (!found) begin
      wx = wt_x ? wt_x : 1;
      wy = wt_y ? wt_y : 1;
      for (int i = 0; i < n_pts; i++) begin
        dx = absl(tab_x[i] - virt_x);
        dy = absl(tab_y[i] - virt_y);
        w = dx * dx * wx + dy * dy * wy;
        if (!found || w < bw) begin
          found = 1; bw = w; best = i;
        end
      end
    end
    sel_ok = 1;
    sel_idx = best;
    cur_x = sat_pix(round_pix(tab_x[best]));
    cur_y = sat_pix(round_pix(tab_y[best]));
  endtask

  task automatic push_cursor();
    cursor_t c;
    c.cx = cur_x[14:0];
    c.cy = cur_y[14:0];
    c.hit = sel_ok;
    c.idx = sel_ok ? sel_idx[3:0] : 4'd0;
    cursors_due.push_back(c);
  endtask

  task automatic predict_cursor(cmd_t c);
    longint pos, org, sz;
    bit tgt;
    tgt = (t_w != 0) && (t_h != 0);
    case (c.op)
      OP_MOVE_X, OP_MOVE_Y: begin
        if (!tgt) return;
        org = (c.op == OP_MOVE_X) ? t_left : t_top;
        sz = (c.op == OP_MOVE_X) ? t_w : t_h;
        pos = org * 16 + (longint'(c.cv) * sz * 32 + 127) / 254;
        if (c.op == OP_MOVE_X) begin
          virt_x = pos; lane_x = pos; axis = AX_X;
        end else begin
          virt_y = pos; lane_y = pos; axis = AX_Y;
        end
        if (n_pts > 0) snap_to_point();
        else begin
          sel_ok = 0; sel_idx = 0;
          if (c.op == OP_MOVE_X) cur_x = sat_pix(round_pix(pos));
          else cur_y = sat_pix(round_pix(pos));
        end
        push_cursor();
      end
      OP_APPEND: begin
        if (list_done) begin
          list_done = 0; n_pts = 0; sel_ok = 0; sel_idx = 0; axis = AX_NONE;
        end
        if (!tgt) return;
        if (n_pts < LSPS_MAX_POINTS) begin
          tab_x[n_pts] = longint'($signed(c.px));
          tab_y[n_pts] = longint'($signed(c.py));
          n_pts++;
        end
        if (!c.lp) return;
        list_done = 1;
        axis = AX_NONE;
        lane_x = cur_x * 16;
        lane_y = cur_y * 16;
        snap_to_point();
        push_cursor();
      end
      default: begin
        n_pts = 0; list_done = 0; axis = AX_NONE; sel_ok = 0; sel_idx = 0;
        cur_x = sat_pix(t_left + t_w / 2);
        cur_y = sat_pix(t_top + t_h / 2);
        virt_x = cur_x * 16; virt_y = cur_y * 16;
        lane_x = virt_x; lane_y = virt_y;
        if (tgt) push_cursor();
      end
    endcase
  endtask

  task automatic report(string what, longint want, longint got);
    $display("%0t %s: expected %0d got %0d", $realtime, what, want, got);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    cmd_t c;
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 0;
      end else if (pending.size() > 0) begin
        c = pending.pop_front();
        opcode <= c.op;
        ctrl_value <= c.cv;
        point_x <= c.px;
        point_y <= c.py;
        last_point <= c.lp;
        in_valid <= 1;
        if (bursts_on && $urandom_range(0, 3) == 0) in_gap <= $urandom_range(1, 3);
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver stall bursts
  always @(posedge clk) begin
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1;
    end else if (bursts_on && $urandom_range(0, 4) == 0) begin
      out_gap <= $urandom_range(0, 2);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    cmd_t c;
    cursor_t e;
    if (!rst && in_valid && !in_stall) begin
      c.op = opcode; c.cv = ctrl_value; c.px = point_x; c.py = point_y;
      c.lp = last_point;
      predict_cursor(c);
    end
    if (!rst && out_valid && !out_stall) begin
      if (cursors_due.size() == 0) begin
        $display("%0t unexpected transaction", $realtime);
        errors++;
      end else begin
        e = cursors_due.pop_front();
        if (cursor_x !== e.cx) report("cursor_x", $signed(e.cx), cursor_x);
        if (cursor_y !== e.cy) report("cursor_y", $signed(e.cy), cursor_y);
        if (point_chosen !== e.hit) report("point_chosen", e.hit, point_chosen);
        if (chosen_index !== e.idx) report("chosen_index", e.idx, chosen_index);
      end
    end
  end

  task automatic set_reg(logic [2:0] idx, longint val);
    @(posedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val[14:0];
    case (idx)
      REG_TARGET_LEFT:   t_left = longint'($signed(val[14:0]));
      REG_TARGET_TOP:    t_top = longint'($signed(val[14:0]));
      REG_TARGET_WIDTH:  t_w = val & 16'h7fff;
      REG_TARGET_HEIGHT: t_h = val & 16'h7fff;
      REG_LANE_TOL:      lane_tol = val & 8'hff;
      REG_X_WEIGHT:      wt_x = val & 12'hfff;
      default:           wt_y = val & 12'hfff;
    endcase
  endtask

  task automatic setup(longint l, longint t, longint w, longint h, longint tol,
                       longint wx, longint wy);
    set_reg(REG_TARGET_LEFT, l);
    set_reg(REG_TARGET_TOP, t);
    set_reg(REG_TARGET_WIDTH, w);
    set_reg(REG_TARGET_HEIGHT, h);
    set_reg(REG_LANE_TOL, tol);
    set_reg(REG_X_WEIGHT, wx);
    set_reg(REG_Y_WEIGHT, wy);
    @(posedge clk);
    cfg_write <= 0;
  endtask

  task automatic add_cmd(logic [1:0] op, logic [6:0] cv, longint px, longint py,
                         logic lp);
    cmd_t c;
    c.op = op; c.cv = cv; c.px = px[18:0]; c.py = py[18:0]; c.lp = lp;
    pending.push_back(c);
  endtask

  function automatic longint pick_coord(longint org, longint sz);
    if ($urandom_range(0, 3) == 0) return longint'($urandom_range(0, 19'h7ffff));
    return (org + $urandom_range(0, sz)) * 16 + $urandom_range(0, 15);
  endfunction

  task automatic add_random(int count);
    int added, r, n;
    longint px, py;
    added = 0;
    while (added < count) begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        n = (r == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
        px = pick_coord(t_left, t_w);
        py = pick_coord(t_top, t_h);
        for (int i = 0; i < n; i++) begin
          // a neighbor keeps the row or column of the one before unless both are redrawn, so the lanes get hits
          case ($urandom_range(0, 2))
            0: px = pick_coord(t_left, t_w);
            1: py = pick_coord(t_top, t_h);
            default: begin
              px = pick_coord(t_left, t_w);
              py = pick_coord(t_top, t_h);
            end
          endcase
          add_cmd(OP_APPEND, $urandom, px + $urandom_range(0, 40) - 20,
                  py + $urandom_range(0, 40) - 20, i == n - 1);
        end
        added += n;
      end else if (r == 4) begin
        add_cmd(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
        added++;
      end else if (r == 5) begin
        add_cmd($urandom, $urandom, $urandom, $urandom, $urandom);
        added++;
      end else begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
          add_cmd($urandom_range(OP_MOVE_X, OP_MOVE_Y), $urandom, $urandom, $urandom, 0);
        added += n;
      end
    end
  endtask

  task automatic drain();
    while (pending.size() > 0 || in_valid || cursors_due.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    #20_000_000;
    $display("lane_snap_pointer_selector: mismatch");
    $finish;
  end

  initial begin
    reset_predictor();
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // no target: moves and appends give nothing
    add_cmd(OP_MOVE_X, 7'd127, 0, 0, 0);
    add_cmd(OP_MOVE_Y, 7'd0, 0, 0, 0);
    add_cmd(OP_APPEND, 0, 16, 16, 1);
    add_cmd(OP_CLEAR, 0, 0, 0, 0);
    drain();

    setup(10, -5, 200, 100, 8, 256, 256);
    add_cmd(OP_CLEAR, 0, 0, 0, 0);
    add_cmd(OP_MOVE_X, 7'd0, 0, 0, 0);
    add_cmd(OP_MOVE_Y, 7'd127, 0, 0, 0);
    add_cmd(OP_APPEND, 0, -262144, 262143, 0);
    add_cmd(OP_APPEND, 0, 262143, -262144, 1);
    add_cmd(OP_MOVE_X, 7'd64, 0, 0, 0);
    add_cmd(OP_MOVE_Y, 7'd1, 0, 0, 0);
    add_cmd(OP_APPEND, 0, -24, 24, 0);
    add_cmd(OP_APPEND, 0, 200 * 16, -24, 0);
    add_cmd(OP_APPEND, 0, 50 * 16, 40 * 16, 1);
    add_cmd(OP_MOVE_X, 7'd100, 0, 0, 0);
    add_cmd(OP_MOVE_Y, 7'd40, 0, 0, 0);
    for (int i = 0; i < 18; i++)
      add_cmd(OP_APPEND, 0, i * 160, (i % 3) * 16, i == 17);
    add_cmd(OP_MOVE_X, 7'd127, 0, 0, 0);
    add_cmd(OP_CLEAR, 0, 0, 0, 0);
    add_random(350);
    drain();

    setup(-16384, -16384, 16384, 16384, 1, 1, 4095);
    add_random(350);
    drain();

    setup(16383, 16383, 32767, 1, 128, 4095, 1);
    add_random(300);
    drain();

    setup(-100, 50, 640, 480, 0, 0, 0);
    add_random(350);
    drain();

    setup(0, 0, 0, 300, 255, 17, 900);
    add_random(60);
    drain();

    bursts_on = 0;
    setup(0, 0, 1920, 1080, 20, 300, 200);
    add_random(600);
    drain();

    if (errors == 0 && cursors_due.size() == 0) begin
      $display("lane_snap_pointer_selector: match");
    end else begin
      $display("lane_snap_pointer_selector: mismatch");
    end
    $finish;
  end

endmodule
